FILE: hdl/acd_pkg.sv
// Shared constants, status codes and control/status bundles for the
// abelian cube detector. No dependencies.
package acd_pkg;

    localparam int MAX_LEN = 4096;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = ADDR_W + 1;
    localparam int CNT_W   = ADDR_W;
    localparam int ARM_W   = 11;
    localparam int PFX_W   = 4 * CNT_W;
    localparam int ENT_W   = PFX_W + 1;

    // result status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;
    localparam logic [1:0] ST_OVER    = 2'd3;

    // read address selection
    localparam logic [1:0] RS_FIRST = 2'd0;
    localparam logic [1:0] RS_NEXT  = 2'd1;
    localparam logic [1:0] RS_MID   = 2'd2;
    localparam logic [1:0] RS_LAST  = 2'd3;

    typedef struct packed {
        logic       store;
        logic [1:0] rsel;
        logic       lat0;
        logic       lat1;
        logic       next;
        logic       found;
        logic       load_out;
        logic [1:0] code;
    } t_cmd;

    typedef struct packed {
        logic stopped;
        logic over;
        logic short_word;
        logic hit;
        logic more;
    } t_sts;

endpackage

FILE: hdl/acd_ctrl.sv
// Sequencer of the abelian cube detector: handshakes and the per-arm
// read/check loop. Depends on acd_pkg.
module acd_ctrl import acd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_bit_valid,
    output logic o_bit_ready,
    output logic o_res_valid,
    input  logic i_res_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_code, n_code;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_out_valid = r_out_valid & ~i_res_ready;
        o_cmd       = '0;
        o_cmd.rsel  = RS_FIRST;
        o_cmd.code  = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_bit_valid) begin
                    if (i_sts.stopped) begin
                        n_code  = ST_STOPPED;
                        n_state = S_RES;
                    end else if (i_sts.over) begin
                        n_code  = ST_OVER;
                        n_state = S_RES;
                    end else begin
                        o_cmd.store = 1'b1;
                        if (i_sts.short_word) begin
                            n_code  = ST_NONE;
                            n_state = S_RES;
                        end else begin
                            n_state = S_RD0;
                        end
                    end
                end
            end
            S_RD0: begin
                o_cmd.rsel = RS_FIRST;
                n_state    = S_RD1;
            end
            S_RD1: begin
                o_cmd.rsel = RS_MID;
                o_cmd.lat0 = 1'b1;
                n_state    = S_RD2;
            end
            S_RD2: begin
                o_cmd.rsel = RS_LAST;
                o_cmd.lat1 = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (i_sts.hit) begin
                    o_cmd.found = 1'b1;
                    n_code      = ST_FOUND;
                    n_state     = S_RES;
                end else if (i_sts.more) begin
                    // overlap the first reads of the next arm with this check
                    o_cmd.next = 1'b1;
                    o_cmd.rsel = RS_NEXT;
                    n_state    = S_RD1;
                end else begin
                    n_code  = ST_NONE;
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (!r_out_valid || i_res_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_code <= n_code;
    end

    assign o_bit_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

endmodule

FILE: hdl/acd_datapath.sv
// Datapath of the abelian cube detector: bit/prefix-count memory, arm
// pointers, block comparison and result register. Depends on acd_pkg.
module acd_datapath import acd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic              i_bit_req,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_start_pos,
    output logic [ARM_W-1:0]  o_arm_len,
    output logic [LEN_W-1:0]  o_word_length
);

    // entry j: {bit j, counts of 00/01/10/11 starting at 0 .. j-1}
    logic [ENT_W-1:0]  r_mem [MAX_LEN];
    logic [ENT_W-1:0]  r_rd_a, r_rd_b;
    logic [ENT_W-1:0]  r_a0, r_b0, r_a1, r_b1;

    logic [LEN_W-1:0]  r_max_len, r_len;
    logic              r_stopped;
    logic              r_last_bit;
    logic [PFX_W-1:0]  r_last_pfx;
    logic [ADDR_W-1:0] r_s, r_p1, r_p2;
    logic [ARM_W-1:0]  r_m;

    logic [LEN_W-1:0]  w_limit;
    logic [ADDR_W-1:0] w_wr_addr, w_addr_a, w_addr_b;
    logic [PFX_W-1:0]  w_pfx;
    logic [1:0]        w_pair;
    logic              w_first_eq, w_last_eq, w_cnt_eq;

    assign w_limit   = (r_max_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : r_max_len;
    assign w_wr_addr = r_len[ADDR_W-1:0];
    assign w_pair    = {r_last_bit, i_bit_req};

    // prefix counts for the new entry: bump the count of the newest pair (all zero for the first entry)
    always_comb begin
        w_pfx = r_last_pfx;
        for (int k = 0; k < 4; k++) begin
            if (w_pair == 2'(k)) begin
                w_pfx[k*CNT_W +: CNT_W] = r_last_pfx[k*CNT_W +: CNT_W] + CNT_W'(1);
            end
        end
        if (r_len == '0) begin
            w_pfx = '0;
        end
    end

    always_comb begin
        case (i_cmd.rsel)
            RS_FIRST: begin
                w_addr_a = r_s;
                w_addr_b = r_p1 - ADDR_W'(1);
            end
            RS_NEXT: begin
                w_addr_a = r_s - ADDR_W'(3);
                w_addr_b = r_p1 - ADDR_W'(3);
            end
            RS_MID: begin
                w_addr_a = r_p1;
                w_addr_b = r_p2 - ADDR_W'(1);
            end
            default: begin
                w_addr_a = r_p2;
                w_addr_b = r_p2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[w_wr_addr] <= {i_bit_req, w_pfx};
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    // three blocks: [s, p1), [p1, p2), [p2, e)
    always_comb begin
        logic [CNT_W-1:0] d_a, d_b, d_c;
        w_first_eq = (r_a0[PFX_W] == r_a1[PFX_W]) && (r_a1[PFX_W] == r_rd_a[PFX_W]);
        w_last_eq  = (r_b0[PFX_W] == r_b1[PFX_W]) && (r_b1[PFX_W] == r_last_bit);
        w_cnt_eq   = 1'b1;
        for (int k = 0; k < 4; k++) begin
            d_a = r_b0[k*CNT_W +: CNT_W] - r_a0[k*CNT_W +: CNT_W];
            d_b = r_b1[k*CNT_W +: CNT_W] - r_a1[k*CNT_W +: CNT_W];
            d_c = r_last_pfx[k*CNT_W +: CNT_W] - r_rd_a[k*CNT_W +: CNT_W];
            if ((d_a != d_b) || (d_b != d_c)) begin
                w_cnt_eq = 1'b0;
            end
        end
    end

    assign o_sts.stopped    = r_stopped;
    assign o_sts.over       = (r_len >= w_limit);
    assign o_sts.short_word = (r_len < LEN_W'(2));
    assign o_sts.hit        = w_first_eq & w_last_eq & w_cnt_eq;
    assign o_sts.more       = (r_s >= ADDR_W'(3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= LEN_W'(MAX_LEN);
            r_len     <= '0;
            r_stopped <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
            if (i_cmd.store) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (i_cmd.found) begin
                r_stopped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_last_bit <= i_bit_req;
            r_last_pfx <= w_pfx;
            r_s        <= w_wr_addr - ADDR_W'(2);
            r_p1       <= w_wr_addr - ADDR_W'(1);
            r_p2       <= w_wr_addr;
            r_m        <= ARM_W'(1);
        end else if (i_cmd.next) begin
            r_s  <= r_s - ADDR_W'(3);
            r_p1 <= r_p1 - ADDR_W'(2);
            r_p2 <= r_p2 - ADDR_W'(1);
            r_m  <= r_m + ARM_W'(1);
        end
        if (i_cmd.lat0) begin
            r_a0 <= r_rd_a;
            r_b0 <= r_rd_b;
        end
        if (i_cmd.lat1) begin
            r_a1 <= r_rd_a;
            r_b1 <= r_rd_b;
        end
        if (i_cmd.load_out) begin
            o_status      <= i_cmd.code;
            o_word_length <= r_len;
            if (i_cmd.code == ST_FOUND) begin
                o_start_pos <= r_s;
                o_arm_len   <= r_m;
            end else begin
                o_start_pos <= '0;
                o_arm_len   <= '0;
            end
        end
    end

endmodule

FILE: hdl/abelian_cube_detector.sv
// Top level of the abelian cube detector: sequencer plus datapath.
// Depends on acd_pkg, acd_ctrl and acd_datapath.
//
// Usage:
//   Bits of a binary word arrive on the bit channel (i_bit_valid,
//   o_bit_ready, i_bit_req), one per transfer. Each transfer yields exactly
//   one result on the result channel (o_res_valid, i_res_ready): status,
//   start_pos, arm_len and word_length.
//   The config channel (i_cfg_valid, o_cfg_ready, i_cfg_data) writes the
//   word length limit; it is always ready. Write it only while idle.
//   A bit that is stopped, beyond the limit or makes a word shorter than
//   three bits goes straight to the result without an arm check.
//   Otherwise, at word length e, the arms m = 1 .. e/3 are checked in
//   turn; each arm reads five entries of the bit/prefix memory through
//   its two read ports. One bit is processed at a time; the next bit is
//   taken once the current result sits in the output register, even if
//   the receiver holds it.
//   Reset: synchronous, active low. Clears the word length, the stop flag
//   and the result valid; the limit returns to 4096. The memory needs no
//   clearing since only entries written since reset are ever read.
//   Receiver stall: the result register holds; the block finishes the
//   next bit's work and then waits until the held result is taken.
module abelian_cube_detector import acd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic              i_bit_valid,
    output logic              o_bit_ready,
    input  logic              i_bit_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_start_pos,
    output logic [ARM_W-1:0]  o_arm_len,
    output logic [LEN_W-1:0]  o_word_length
);

    t_cmd w_cmd;
    t_sts w_sts;

    // config writes land at once, no back-pressure
    assign o_cfg_ready = 1'b1;

    acd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bit_valid (i_bit_valid),
        .o_bit_ready (o_bit_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    acd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_bit_req     (i_bit_req),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_status      (o_status),
        .o_start_pos   (o_start_pos),
        .o_arm_len     (o_arm_len),
        .o_word_length (o_word_length)
    );

endmodule

FILE: hdl/acd_checker.sv
// Port-level checks for the abelian cube detector, bound to the top level.
// Depends on acd_pkg.
module acd_checker import acd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_res_valid,
    input logic              i_res_ready,
    input logic [1:0]        o_status,
    input logic [ADDR_W-1:0] o_start_pos,
    input logic [ARM_W-1:0]  o_arm_len,
    input logic [LEN_W-1:0]  o_word_length
);

    // held result stays put while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_status)
            && $stable(o_start_pos) && $stable(o_arm_len) && $stable(o_word_length))
        else $error("result changed while stalled");

    // a found cube ends exactly at the current word end
    a_cube_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_status == ST_FOUND) |->
            (o_arm_len != '0) && ((14'(o_start_pos) + 14'(o_arm_len) * 14'd3)
                == 14'(o_word_length)))
        else $error("cube position inconsistent with word length");

    // no cube: position fields are zero
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_status != ST_FOUND) |-> (o_start_pos == '0) && (o_arm_len == '0))
        else $error("position reported without a cube");

    // word never grows past the storage depth
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_word_length <= LEN_W'(MAX_LEN)))
        else $error("word length beyond storage");

endmodule

bind abelian_cube_detector acd_checker u_acd_checker (.*);
